// ===== sv/moving_sphere_collision_time_macros.svh =====
// assertion helpers used by the top-level rtl, clocked on clk and quiet during reset
`ifndef MOVING_SPHERE_COLLISION_TIME_MACROS_SVH
`define MOVING_SPHERE_COLLISION_TIME_MACROS_SVH

// same-cycle implication
`define MSCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/msct_pkg.sv =====
`timescale 1ns / 1ps
package msct_pkg;

  localparam int COORD_WIDTH    = 20;
  localparam int VEL_WIDTH      = 16;
  localparam int TIME_FRAC_BITS = 16;
  localparam int RADIUS_WIDTH   = 10;
  localparam int FRAC_BITS      = 8;
  localparam int TIME_W         = 32;
  localparam int STATUS_W       = 2;

  function automatic int max2(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

  // magnitudes of relative position and velocity
  localparam int S_W   = COORD_WIDTH + 1;
  localparam int V_W   = VEL_WIDTH + 1;
  // radius sum in q.8
  localparam int R_W   = RADIUS_WIDTH + 1 + FRAC_BITS;
  localparam int RR_W  = 2 * R_W;
  localparam int SS_W  = 2 * S_W;
  localparam int A_W   = 2 * V_W;
  localparam int BM_W  = S_W + V_W;
  localparam int B_W   = BM_W + 1;
  localparam int CMP_W = max2(SS_W, RR_W) + 1;
  localparam int RT_W  = max2(BM_W, (A_W + SS_W + 1) / 2);
  localparam int D_W   = 2 * RT_W;
  localparam int DV_W  = max2(BM_W, RT_W) + 1;
  localparam int NUM_W = SS_W + TIME_FRAC_BITS;

  // shift-add multiplier sizing
  localparam int MC_W  = max2(max2(SS_W, BM_W), R_W);
  localparam int MP_W  = max2(max2(BM_W, A_W), R_W);
  localparam int P_W   = MC_W + MP_W;
  localparam int CNT_W = $clog2(MP_W + 1);

  localparam int SQ_CNT_W  = $clog2(RT_W + 1);
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERLAP  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RECEDING = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOT  = 2'd3;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mul_ctl_t;

endpackage

// ===== sv/msct_mul.sv =====
`timescale 1ns / 1ps
module msct_mul import msct_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  mul_ctl_t        ctl,
  input  logic [MC_W-1:0] mc,
  input  logic [MP_W-1:0] mp,
  output logic            done,
  output logic [P_W-1:0]  prod
);

  logic [P_W-1:0]   mc_r;
  logic [P_W-1:0]   acc_r;
  logic [MP_W-1:0]  mp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  // multiplier bits leave lsb first, multiplicand walks left
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        mc_r  <= P_W'(mc);
        mp_r  <= mp;
        acc_r <= '0;
        cnt_r <= ctl.nbits;
      end else if (cnt_r != '0) begin
        if (mp_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r   <= mc_r << 1;
        mp_r   <= mp_r >> 1;
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== sv/msct_sqrt.sv =====
`timescale 1ns / 1ps
module msct_sqrt import msct_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [D_W-1:0]  rad,
  output logic            done,
  output logic [RT_W-1:0] root
);

  logic [D_W-1:0]      rad_r;
  logic [RT_W:0]       rem_r;
  logic [RT_W-1:0]     root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                done_r;
  logic [RT_W+2:0]     rem_sh;
  logic [RT_W+2:0]     trial;
  logic [RT_W+2:0]     diff;
  logic                fits;

  // two radicand bits per step, one root bit out
  always_comb begin
    rem_sh = {rem_r, rad_r[D_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= SQ_CNT_W'(RT_W);
      end else if (cnt_r != '0) begin
        rad_r <= rad_r << 2;
        if (fits) begin
          rem_r  <= diff[RT_W:0];
          root_r <= {root_r[RT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[RT_W:0];
          root_r <= {root_r[RT_W-2:0], 1'b0};
        end
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == SQ_CNT_W'(1));
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== sv/msct_div.sv =====
`timescale 1ns / 1ps
module msct_div import msct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DV_W-1:0]   den,
  output logic              done,
  output logic [TIME_W-1:0] quo
);

  logic [NUM_W-1:0]     num_r;
  logic [DV_W-1:0]      den_r;
  logic [DV_W-1:0]      rem_r;
  logic [TIME_W-1:0]    q_r;
  logic                 sat_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DV_W:0]        rem_sh;
  logic [DV_W:0]        diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  // restoring division, one quotient bit per cycle; a bit pushed out of
  // the top of the quotient means saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r <= num;
        den_r <= den;
        rem_r <= '0;
        q_r   <= '0;
        sat_r <= 1'b0;
        cnt_r <= DIV_CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        num_r  <= num_r << 1;
        rem_r  <= ge ? diff[DV_W-1:0] : rem_sh[DV_W-1:0];
        q_r    <= {q_r[TIME_W-2:0], ge};
        sat_r  <= sat_r | q_r[TIME_W-1];
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == DIV_CNT_W'(1));
      end
    end
  end

  assign done = done_r;
  assign quo  = sat_r ? '1 : q_r;

endmodule

// ===== sv/moving_sphere_collision_time.sv =====
`timescale 1ns / 1ps
// channel  ports                                          handshake
// input    in_operation, in_pos_*, in_vel_*, in_radius    taken when start && !busy
// result   out_status, out_collision_time                 out_valid, one cycle
//
// a store word is taken straight from idle and leaves busy low
// a compute word runs one shift-add multiplier (one multiplier bit per cycle),
// a bit-serial square root and a bit-serial divider (the last two only for a hit):
// the result word comes soonest for an overlap, then for receding, no root and a hit;
// busy is low again in the result cycle
// synchronous active-low reset clears the stored sphere and the sequencer
// the result is shown for one cycle and cannot be held off
`include "moving_sphere_collision_time_macros.svh"
module moving_sphere_collision_time import msct_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [VEL_WIDTH-1:0]   in_vel_x,
  input  logic signed [VEL_WIDTH-1:0]   in_vel_y,
  input  logic signed [VEL_WIDTH-1:0]   in_vel_z,
  input  logic [RADIUS_WIDTH-1:0]       in_radius,
  output logic                          out_valid,
  output logic [STATUS_W-1:0]           out_status,
  output logic [TIME_W-1:0]             out_collision_time
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_EVAL,
    ST_SQRT_GO, ST_SQRT_WAIT, ST_DIV_GO, ST_DIV_WAIT
  } state_t;

  typedef enum logic [2:0] {
    STEP_SS, STEP_RR, STEP_B, STEP_A, STEP_BB, STEP_AC
  } step_t;

  localparam logic [1:0] LANE_LAST = 2'd2;

  state_t state_r;
  step_t  step_r;
  logic [1:0] lane_r;

  logic [COORD_WIDTH-1:0]  fp_r [3];
  logic [VEL_WIDTH-1:0]    fv_r [3];
  logic [RADIUS_WIDTH-1:0] fr_r;

  logic [S_W-1:0]  s_r [3];
  logic [V_W-1:0]  v_r [3];
  logic [R_W-1:0]  r_r;
  logic [SS_W-1:0] ss_r;
  logic [RR_W-1:0] rr_r;
  logic [B_W-1:0]  b_r;
  logic [BM_W-1:0] bm_r;
  logic [A_W-1:0]  a_r;
  logic [D_W-1:0]  d_r;
  logic [D_W-1:0]  ac_r;
  logic [DV_W-1:0] den_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TIME_W-1:0]   out_time_r;

  logic [S_W-1:0]   s_mag;
  logic [V_W-1:0]   v_mag;
  logic             prod_neg;
  logic [CMP_W-1:0] ov_diff;
  logic [D_W:0]     disc_diff;

  mul_ctl_t          mul_ctl;
  logic [MC_W-1:0]   mul_mc;
  logic [MP_W-1:0]   mul_mp;
  logic              mul_done;
  logic [P_W-1:0]    mul_prod;
  logic              sq_done;
  logic [RT_W-1:0]   sq_root;
  logic              dv_done;
  logic [TIME_W-1:0] dv_quo;

  always_comb begin
    s_mag     = s_r[0][S_W-1] ? (S_W'(~s_r[0]) + S_W'(1)) : s_r[0];
    v_mag     = v_r[0][V_W-1] ? (V_W'(~v_r[0]) + V_W'(1)) : v_r[0];
    prod_neg  = s_r[0][S_W-1] ^ v_r[0][V_W-1];
    ov_diff   = CMP_W'(ss_r) - CMP_W'(rr_r);
    disc_diff = {1'b0, d_r} - {1'b0, ac_r};
  end

  // operands of the current multiply step; lane 0 of the rotating
  // position and velocity registers is always the active axis
  always_comb begin
    mul_ctl.start = (state_r == ST_MUL_GO);
    case (step_r)
      STEP_SS: begin
        mul_mc        = MC_W'(s_mag);
        mul_mp        = MP_W'(s_mag);
        mul_ctl.nbits = CNT_W'(S_W);
      end
      STEP_RR: begin
        mul_mc        = MC_W'(r_r);
        mul_mp        = MP_W'(r_r);
        mul_ctl.nbits = CNT_W'(R_W);
      end
      STEP_B: begin
        mul_mc        = MC_W'(s_mag);
        mul_mp        = MP_W'(v_mag);
        mul_ctl.nbits = CNT_W'(V_W);
      end
      STEP_A: begin
        mul_mc        = MC_W'(v_mag);
        mul_mp        = MP_W'(v_mag);
        mul_ctl.nbits = CNT_W'(V_W);
      end
      STEP_BB: begin
        mul_mc        = MC_W'(bm_r);
        mul_mp        = MP_W'(bm_r);
        mul_ctl.nbits = CNT_W'(BM_W);
      end
      STEP_AC: begin
        mul_mc        = MC_W'(ss_r);
        mul_mp        = MP_W'(a_r);
        mul_ctl.nbits = CNT_W'(A_W);
      end
      default: begin
        mul_mc        = '0;
        mul_mp        = '0;
        mul_ctl.nbits = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_SS;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        fp_r[i] <= '0;
        fv_r[i] <= '0;
      end
      fr_r <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            if (!in_operation) begin
              fp_r[0] <= in_pos_x;
              fp_r[1] <= in_pos_y;
              fp_r[2] <= in_pos_z;
              fv_r[0] <= in_vel_x;
              fv_r[1] <= in_vel_y;
              fv_r[2] <= in_vel_z;
              fr_r    <= in_radius;
            end else begin
              s_r[0] <= S_W'($signed(fp_r[0])) - S_W'(in_pos_x);
              s_r[1] <= S_W'($signed(fp_r[1])) - S_W'(in_pos_y);
              s_r[2] <= S_W'($signed(fp_r[2])) - S_W'(in_pos_z);
              v_r[0] <= V_W'($signed(fv_r[0])) - V_W'(in_vel_x);
              v_r[1] <= V_W'($signed(fv_r[1])) - V_W'(in_vel_y);
              v_r[2] <= V_W'($signed(fv_r[2])) - V_W'(in_vel_z);
              r_r    <= R_W'({1'b0, fr_r} + {1'b0, in_radius}) << FRAC_BITS;
              ss_r   <= '0;
              b_r    <= '0;
              a_r    <= '0;
              step_r <= STEP_SS;
              lane_r <= '0;
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_MUL_GO: state_r <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (step_r)
              STEP_SS: begin
                ss_r   <= ss_r + mul_prod[SS_W-1:0];
                s_r[0] <= s_r[1];
                s_r[1] <= s_r[2];
                s_r[2] <= s_r[0];
              end
              STEP_RR: rr_r <= mul_prod[RR_W-1:0];
              STEP_B: begin
                b_r    <= prod_neg ? (b_r - B_W'(mul_prod[BM_W-1:0]))
                                   : (b_r + B_W'(mul_prod[BM_W-1:0]));
                s_r[0] <= s_r[1];
                s_r[1] <= s_r[2];
                s_r[2] <= s_r[0];
                v_r[0] <= v_r[1];
                v_r[1] <= v_r[2];
                v_r[2] <= v_r[0];
              end
              STEP_A: begin
                a_r    <= a_r + mul_prod[A_W-1:0];
                v_r[0] <= v_r[1];
                v_r[1] <= v_r[2];
                v_r[2] <= v_r[0];
              end
              STEP_BB: d_r  <= mul_prod[D_W-1:0];
              STEP_AC: ac_r <= mul_prod[D_W-1:0];
              default: ;
            endcase
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          case (step_r)
            STEP_SS: begin
              if (lane_r == LANE_LAST) begin
                lane_r <= '0;
                step_r <= STEP_RR;
              end else begin
                lane_r <= lane_r + 1'b1;
              end
              state_r <= ST_MUL_GO;
            end
            STEP_RR: begin
              if (ov_diff[CMP_W-1]) begin
                out_valid_r  <= 1'b1;
                out_status_r <= STATUS_OVERLAP;
                out_time_r   <= '0;
                state_r      <= ST_IDLE;
              end else begin
                // ss_r holds c from here on
                ss_r    <= ov_diff[SS_W-1:0];
                step_r  <= STEP_B;
                state_r <= ST_MUL_GO;
              end
            end
            STEP_B: begin
              if (lane_r != LANE_LAST) begin
                lane_r  <= lane_r + 1'b1;
                state_r <= ST_MUL_GO;
              end else if (!b_r[B_W-1]) begin
                out_valid_r  <= 1'b1;
                out_status_r <= STATUS_RECEDING;
                out_time_r   <= '0;
                state_r      <= ST_IDLE;
              end else begin
                bm_r    <= BM_W'(-b_r);
                lane_r  <= '0;
                step_r  <= STEP_A;
                state_r <= ST_MUL_GO;
              end
            end
            STEP_A: begin
              if (lane_r == LANE_LAST) begin
                lane_r <= '0;
                step_r <= STEP_BB;
              end else begin
                lane_r <= lane_r + 1'b1;
              end
              state_r <= ST_MUL_GO;
            end
            STEP_BB: begin
              step_r  <= STEP_AC;
              state_r <= ST_MUL_GO;
            end
            STEP_AC: begin
              if (disc_diff[D_W]) begin
                out_valid_r  <= 1'b1;
                out_status_r <= STATUS_NO_ROOT;
                out_time_r   <= '0;
                state_r      <= ST_IDLE;
              end else begin
                d_r     <= disc_diff[D_W-1:0];
                state_r <= ST_SQRT_GO;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_SQRT_GO: state_r <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (sq_done) begin
            // rationalized divisor -b + sqrt(d), never zero here
            den_r   <= DV_W'(bm_r) + DV_W'(sq_root);
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (dv_done) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STATUS_HIT;
            out_time_r   <= dv_quo;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  msct_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .mc    (mul_mc),
    .mp    (mul_mp),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  msct_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_SQRT_GO),
    .rad   (d_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  msct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIV_GO),
    .num   ({ss_r, {TIME_FRAC_BITS{1'b0}}}),
    .den   (den_r),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_collision_time = out_time_r;

  `MSCT_ASSERT_IMP(a_strobe_when_idle, out_valid_r, !busy, "result word while busy")
  `MSCT_ASSERT_NXT(a_single_strobe, out_valid_r, !out_valid_r, "result word repeated")
  `MSCT_ASSERT_NXT(a_compute_goes_busy, start && !busy && in_operation, busy, "compute not started")
  `MSCT_ASSERT_IMP(a_time_only_on_hit, out_valid_r && out_status_r != STATUS_HIT, out_time_r == '0, "time set without hit")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import msct_pkg::*;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;
  localparam int   N_WORDS    = 1950;

  typedef struct packed {
    logic                              op;
    logic [2:0][COORD_WIDTH-1:0]       pos;
    logic [2:0][VEL_WIDTH-1:0]         vel;
    logic [RADIUS_WIDTH-1:0]           rad;
  } sphere_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   ctime;
  } outcome_t;

  typedef struct packed {
    sphere_word_t w;
    logic         typed;
    outcome_t     res;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_operation = 1'b0;
  logic signed [COORD_WIDTH-1:0] in_pos_x = '0;
  logic signed [COORD_WIDTH-1:0] in_pos_y = '0;
  logic signed [COORD_WIDTH-1:0] in_pos_z = '0;
  logic signed [VEL_WIDTH-1:0]   in_vel_x = '0;
  logic signed [VEL_WIDTH-1:0]   in_vel_y = '0;
  logic signed [VEL_WIDTH-1:0]   in_vel_z = '0;
  logic [RADIUS_WIDTH-1:0]       in_radius = '0;
  logic                          out_valid;
  logic [STATUS_W-1:0]           out_status;
  logic [TIME_W-1:0]             out_collision_time;

  // first sphere as the block holds it
  logic [2:0][COORD_WIDTH-1:0] held_pos = '0;
  logic [2:0][VEL_WIDTH-1:0]   held_vel = '0;
  logic [RADIUS_WIDTH-1:0]     held_radius = '0;

  outcome_t pending_outcomes[$];
  dir_row_t dir_rows[$];
  int       mismatch_cnt = 0;
  int       words_sent = 0;
  bit       steady = 1'b0;

  always #2 clk = ~clk;

  moving_sphere_collision_time i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_vel_x          (in_vel_x),
    .in_vel_y          (in_vel_y),
    .in_vel_z          (in_vel_z),
    .in_radius         (in_radius),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_collision_time(out_collision_time)
  );

  function automatic logic [63:0] int_sqrt(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int bitn = 63; bitn >= 0; bitn--) begin
      trial = root | (64'd1 << bitn);
      if ({64'd0, trial} * {64'd0, trial} <= n) root = trial;
    end
    return root;
  endfunction

  // outcome of testing the held sphere against the incoming one
  function automatic outcome_t collision_outcome(sphere_word_t w);
    longint      s[3];
    longint      v[3];
    longint      ss, a, b, rsum, rr, c, bm;
    logic [127:0] disc, ac, num, den, quo;
    logic [63:0] root;
    outcome_t    o;
    ss = 0;
    a = 0;
    b = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'($signed(held_pos[i])) - longint'($signed(w.pos[i]));
      v[i] = longint'($signed(held_vel[i])) - longint'($signed(w.vel[i]));
      ss += s[i] * s[i];
      a  += v[i] * v[i];
      b  += v[i] * s[i];
    end
    rsum = (longint'(held_radius) + longint'(w.rad)) << FRAC_BITS;
    rr = rsum * rsum;
    o.ctime = '0;
    if (ss < rr) begin
      o.status = STATUS_OVERLAP;
      return o;
    end
    c = ss - rr;
    if (b >= 0) begin
      o.status = STATUS_RECEDING;
      return o;
    end
    bm = -b;
    disc = {64'd0, bm} * {64'd0, bm};
    ac = {64'd0, a} * {64'd0, c};
    if (disc < ac) begin
      o.status = STATUS_NO_ROOT;
      return o;
    end
    root = int_sqrt(disc - ac);
    // rationalized form, divisor cannot be zero
    num = {64'd0, c} << TIME_FRAC_BITS;
    den = {64'd0, bm} + {64'd0, root};
    quo = num / den;
    o.status = STATUS_HIT;
    o.ctime = (quo > 128'hFFFF_FFFF) ? '1 : quo[TIME_W-1:0];
    return o;
  endfunction

  function automatic sphere_word_t make_word(logic op, int px, int py, int pz,
                                             int vx, int vy, int vz, int rad);
    sphere_word_t w;
    w.op = op;
    w.pos[0] = COORD_WIDTH'(px);
    w.pos[1] = COORD_WIDTH'(py);
    w.pos[2] = COORD_WIDTH'(pz);
    w.vel[0] = VEL_WIDTH'(vx);
    w.vel[1] = VEL_WIDTH'(vy);
    w.vel[2] = VEL_WIDTH'(vz);
    w.rad = RADIUS_WIDTH'(rad);
    return w;
  endfunction

  function automatic void add_row(sphere_word_t w, logic typed,
                                  logic [STATUS_W-1:0] st, logic [TIME_W-1:0] tm);
    dir_row_t row;
    row.w = w;
    row.typed = typed;
    row.res.status = st;
    row.res.ctime = tm;
    dir_rows.push_back(row);
  endfunction

  function automatic sphere_word_t noise_word();
    sphere_word_t w;
    w.op = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) begin
      w.pos[i] = COORD_WIDTH'($urandom);
      w.vel[i] = VEL_WIDTH'($urandom);
    end
    w.rad = RADIUS_WIDTH'($urandom);
    return w;
  endfunction

  function automatic int rand_radius();
    return int'($urandom_range(0, (1 << $urandom_range(0, RADIUS_WIDTH)) - 1));
  endfunction

  // presents one word and holds it until the block takes it
  task automatic drive_word(sphere_word_t w);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 28) gap++;
      if ($urandom_range(0, 199) == 0) gap += $urandom_range(50, 450);
    end
    if (gap > 0) begin
      start <= 1'b0;
      // idle cycles count only where the block could have taken a word
      repeat (gap) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
    end
    start        <= 1'b1;
    in_operation <= w.op;
    in_pos_x     <= w.pos[0];
    in_pos_y     <= w.pos[1];
    in_pos_z     <= w.pos[2];
    in_vel_x     <= w.vel[0];
    in_vel_y     <= w.vel[1];
    in_vel_z     <= w.vel[2];
    in_radius    <= w.rad;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic issue(sphere_word_t w, logic typed, outcome_t res);
    drive_word(w);
    if (w.op == OP_COMPUTE) begin
      pending_outcomes.push_back(typed ? res : collision_outcome(w));
    end else begin
      held_pos = w.pos;
      held_vel = w.vel;
      held_radius = w.rad;
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // store a sphere, then send a partner aimed roughly at it
  task automatic issue_pair();
    sphere_word_t first, second;
    int sh, vsh, nzm, p2, v2;
    int s[3];
    int v[3];
    outcome_t none;
    none = '0;
    sh = $urandom_range(4, 18);
    vsh = $urandom_range(0, 13);
    for (int i = 0; i < 3; i++) begin
      s[i] = int'($urandom_range(0, (1 << (sh + 1)) - 1)) - (1 << sh);
      if (vsh >= sh) v[i] = -(s[i] <<< (vsh - sh));
      else v[i] = -(s[i] >>> (sh - vsh));
      nzm = (1 << vsh) >> $urandom_range(1, 8);
      v[i] += int'($urandom_range(0, 2 * nzm)) - nzm;
    end
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 3; i++) v[i] = -v[i];
    end
    first.op = OP_STORE;
    second.op = OP_COMPUTE;
    for (int i = 0; i < 3; i++) begin
      p2 = int'($urandom_range(0, (1 << 20) - (1 << (sh + 1)) - 1)) - ((1 << 19) - (1 << sh));
      v2 = int'($urandom_range(0, 1 << 14)) - (1 << 13);
      first.pos[i] = COORD_WIDTH'(p2 + s[i]);
      second.pos[i] = COORD_WIDTH'(p2);
      first.vel[i] = VEL_WIDTH'(v2 + v[i]);
      second.vel[i] = VEL_WIDTH'(v2);
    end
    first.rad = RADIUS_WIDTH'(rand_radius());
    second.rad = RADIUS_WIDTH'(rand_radius());
    issue(first, 1'b0, none);
    issue(second, 1'b0, none);
    if ($urandom_range(0, 3) == 0) begin
      // another partner against the same stored sphere
      for (int i = 0; i < 3; i++) begin
        second.pos[i] = second.pos[i] + COORD_WIDTH'(int'($urandom_range(0, 512)) - 256);
      end
      second.rad = RADIUS_WIDTH'(rand_radius());
      issue(second, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result word: status %0d time %h",
                   out_status, out_collision_time);
        mismatch_cnt++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_status !== want.status || out_collision_time !== want.ctime) begin
          if (mismatch_cnt < 10)
            $display("result mismatch: status exp %0d got %0d, time exp %h got %h",
                     want.status, out_status, want.ctime, out_collision_time);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #(40_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    outcome_t none;
    bit paused;
    none = '0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // compute against the cleared store
    add_row(make_word(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0), 1'b1, STATUS_RECEDING, '0);
    add_row(make_word(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1), 1'b1, STATUS_OVERLAP, '0);
    add_row(make_word(OP_COMPUTE, -2560, 0, 0, 0, 0, 0, 0), 1'b1, STATUS_RECEDING, '0);
    // ten pixels apart closing at one pixel per tick: contact after 8 ticks
    add_row(make_word(OP_STORE, -2560, 0, 0, 256, 0, 0, 1), 1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1), 1'b1, STATUS_HIT, 32'h0008_0000);
    add_row(make_word(OP_COMPUTE, -2560, 0, 0, 0, 0, 0, 1), 1'b1, STATUS_OVERLAP, '0);
    add_row(make_word(OP_COMPUTE, -5120, 0, 0, 0, 0, 0, 1), 1'b1, STATUS_RECEDING, '0);
    // passes ten pixels to the side
    add_row(make_word(OP_STORE, -2560, 2560, 0, 256, 0, 0, 1), 1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1), 1'b1, STATUS_NO_ROOT, '0);
    // just touching counts as a hit at time zero
    add_row(make_word(OP_STORE, -512, 0, 0, 256, 0, 0, 1), 1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1), 1'b1, STATUS_HIT, '0);
    // same velocity, no relative motion
    add_row(make_word(OP_STORE, -2560, 0, 0, 100, -50, 7, 3), 1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 0, 0, 0, 100, -50, 7, 3), 1'b1, STATUS_RECEDING, '0);
    // very slow approach across the whole range saturates the time
    add_row(make_word(OP_STORE, -524288, 0, 0, 1, 0, 0, 0), 1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 524287, 0, 0, 0, 0, 0, 0), 1'b1, STATUS_HIT, '1);
    add_row(make_word(OP_STORE, 524287, 524287, 524287, -32768, -32768, -32768, 1023),
            1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, -524288, -524288, -524288, 32767, 32767, 32767, 1023),
            1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 524287, 524287, 524287, 32767, 32767, 32767, 1023),
            1'b1, STATUS_OVERLAP, '0);
    add_row(make_word(OP_STORE, -524288, 524287, -524288, 32767, -32768, 32767, 0),
            1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 524287, -524288, 524287, -32768, 32767, -32768, 0),
            1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1023), 1'b0, '0, '0);
    add_row(make_word(OP_STORE, 1000, -3000, 77, -20, 60, 3, 5), 1'b0, '0, '0);
    add_row(make_word(OP_COMPUTE, -1000, 2500, 0, 30, -40, 0, 7), 1'b0, '0, '0);

    foreach (dir_rows[i]) issue(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    wait_drained();

    while (words_sent < N_WORDS) begin
      steady = (words_sent >= 800 && words_sent < 1100);
      if (!paused && words_sent >= 1300) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 99) < 15) issue(noise_word(), 1'b0, none);
      else issue_pair();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
